FILE: sv/fcc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FAT16 cluster chain engine.
// No dependencies; used by every module of the block except fcc_ram.
package fcc_pkg;

  localparam int unsigned CLUSTER_W  = 16;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CLUSTER_W-1:0] LINK_END  = 16'hFFFF;
  localparam logic [CLUSTER_W-1:0] LINK_FREE = 16'h0000;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_LONG = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'b1;

  localparam logic [LEN_W-1:0] ENTRIES_RESET = 13'd4096;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_READ_RAW,
    OP_NEXT,
    OP_LAST,
    OP_PREV,
    OP_ALLOC,
    OP_FREE_CHAIN,
    OP_CLEAN
  } opcode_e;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [CLUSTER_W-1:0] cluster;
    logic [CLUSTER_W-1:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] result_cluster;
    logic [STATUS_W-1:0]  status;
    logic                 table_dirty;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_EVAL,
    S_NEXT_EVAL,
    S_LAST_CHK,
    S_LAST_EVAL,
    S_SCAN_CHK,
    S_SCAN_EVAL,
    S_ALLOC_LINK,
    S_ALLOC_END,
    S_FREE_CHK,
    S_FREE_EVAL,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_CAPTURE,
    ACT_WR_LOAD,
    ACT_RD_CL,
    ACT_RD_IDX,
    ACT_RD_CUR_IDX,
    ACT_RD_CUR,
    ACT_RD_SCAN,
    ACT_RES_RDATA,
    ACT_RES_LINK,
    ACT_RES_CUR,
    ACT_RES_CL,
    ACT_RES_SCAN,
    ACT_SET_NONE,
    ACT_SET_LONG,
    ACT_CUR_LINK,
    ACT_SCAN_NEXT,
    ACT_FREE_STEP,
    ACT_WR_ENTRY,
    ACT_WR_END,
    ACT_DIRTY_SET,
    ACT_DIRTY_CLR
  } dp_act_e;

  typedef struct packed {
    dp_act_e act;
    logic    push;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    cl_in_range;
    logic    idx_in_range;
    logic    cl_is_base;
    logic    cl_below_base;
    logic    cl_zero;
    logic    entry_in_range;
    logic    cur_idx_in_range;
    logic    cur_raw_end;
    logic    cnt_at_n;
    logic    scan_done;
    logic    rd_end;
    logic    rd_next_zero;
    logic    rd_match;
    logic    out_busy;
  } dp_status_t;

endpackage

FILE: sv/fat_cluster_chain_engine.sv
`timescale 1ns / 1ps
// FAT16 cluster chain engine: a link table with dirty flag that serves one
// request at a time. Depends on fcc_pkg, fcc_ctrl, fcc_dp (with fcc_ram).
//
// Usage:
//   Requests enter on in_valid_i/in_data_i; a transfer happens when in_valid_i
//   is high and in_stall_o is low. Every request gives exactly one result on
//   out_valid_o/out_data_o, transferred when out_valid_o is high and
//   out_stall_i is low. Configuration (data_base at index 0, entries_in_use at
//   index 1) is written through cfg_we_i/cfg_index_i/cfg_data_i; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Last and free chain walk the chain link by link; prev and allocate scan the
//   table entry by entry. Table reads go through the single read port of the
//   link table. One request is in flight at a time; the next is taken once the
//   previous result sits in the output register, even while the receiver stalls
//   it. A stalled result holds in the output register and the block stops at
//   the end of the following request until the register frees.
//   Reset clears the dirty flag, the config registers (data_base 0,
//   entries_in_use 4096) and the handshake state. The link table is not
//   cleared; fill it with load requests before use.
module fat_cluster_chain_engine #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fcc_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fcc_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fcc_pkg::dp_cmd_t    cmd;
  fcc_pkg::dp_status_t status;

  fcc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .st_i      (status),
    .cmd_o     (cmd)
  );

  fcc_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .st_o       (status)
  );

endmodule

FILE: sv/fcc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/fcc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the cluster chain engine: one request at a time, one datapath
// action per cycle. Depends on fcc_pkg.
module fcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fcc_pkg::dp_status_t st_i,
  output fcc_pkg::dp_cmd_t    cmd_o
);

  fcc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != fcc_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fcc_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fcc_pkg::S_DISPATCH;
      end
      fcc_pkg::S_DISPATCH: begin
        case (st_i.op)
          fcc_pkg::OP_READ_RAW:
            state_d = st_i.cl_in_range ? fcc_pkg::S_READ_EVAL : fcc_pkg::S_DONE;
          fcc_pkg::OP_NEXT:
            state_d = st_i.idx_in_range ? fcc_pkg::S_NEXT_EVAL : fcc_pkg::S_DONE;
          fcc_pkg::OP_LAST:
            state_d = st_i.cl_is_base ? fcc_pkg::S_DONE : fcc_pkg::S_LAST_CHK;
          fcc_pkg::OP_PREV:
            state_d = st_i.cl_below_base ? fcc_pkg::S_DONE : fcc_pkg::S_SCAN_CHK;
          fcc_pkg::OP_ALLOC:      state_d = fcc_pkg::S_SCAN_CHK;
          fcc_pkg::OP_FREE_CHAIN: state_d = fcc_pkg::S_FREE_CHK;
          default:                state_d = fcc_pkg::S_DONE;
        endcase
      end
      fcc_pkg::S_READ_EVAL: state_d = fcc_pkg::S_DONE;
      fcc_pkg::S_NEXT_EVAL: state_d = fcc_pkg::S_DONE;
      fcc_pkg::S_LAST_CHK: begin
        if (!st_i.cur_idx_in_range || st_i.cnt_at_n) state_d = fcc_pkg::S_DONE;
        else state_d = fcc_pkg::S_LAST_EVAL;
      end
      fcc_pkg::S_LAST_EVAL: begin
        if (st_i.rd_end || st_i.rd_next_zero) state_d = fcc_pkg::S_DONE;
        else state_d = fcc_pkg::S_LAST_CHK;
      end
      fcc_pkg::S_SCAN_CHK: begin
        state_d = st_i.scan_done ? fcc_pkg::S_DONE : fcc_pkg::S_SCAN_EVAL;
      end
      fcc_pkg::S_SCAN_EVAL: begin
        if (!st_i.rd_match) begin
          state_d = fcc_pkg::S_SCAN_CHK;
        end else if (st_i.op == fcc_pkg::OP_ALLOC && !st_i.cl_zero) begin
          state_d = fcc_pkg::S_ALLOC_LINK;
        end else begin
          state_d = fcc_pkg::S_DONE;
        end
      end
      fcc_pkg::S_ALLOC_LINK: state_d = fcc_pkg::S_ALLOC_END;
      fcc_pkg::S_ALLOC_END:  state_d = fcc_pkg::S_DONE;
      fcc_pkg::S_FREE_CHK: begin
        if (st_i.cur_raw_end || st_i.cnt_at_n) state_d = fcc_pkg::S_DONE;
        else state_d = fcc_pkg::S_FREE_EVAL;
      end
      fcc_pkg::S_FREE_EVAL: state_d = fcc_pkg::S_FREE_CHK;
      fcc_pkg::S_DONE: begin
        if (!st_i.out_busy) state_d = fcc_pkg::S_IDLE;
      end
      default: state_d = fcc_pkg::S_IDLE;
    endcase
  end

  // datapath action
  always_comb begin
    cmd_o.act  = fcc_pkg::ACT_NONE;
    cmd_o.push = 1'b0;
    case (state_q)
      fcc_pkg::S_IDLE: begin
        if (in_valid_i) cmd_o.act = fcc_pkg::ACT_CAPTURE;
      end
      fcc_pkg::S_DISPATCH: begin
        case (st_i.op)
          fcc_pkg::OP_LOAD:
            cmd_o.act = st_i.cl_in_range ? fcc_pkg::ACT_WR_LOAD : fcc_pkg::ACT_SET_NONE;
          fcc_pkg::OP_READ_RAW:
            cmd_o.act = st_i.cl_in_range ? fcc_pkg::ACT_RD_CL : fcc_pkg::ACT_SET_NONE;
          fcc_pkg::OP_NEXT:
            cmd_o.act = st_i.idx_in_range ? fcc_pkg::ACT_RD_IDX : fcc_pkg::ACT_SET_NONE;
          fcc_pkg::OP_LAST:
            cmd_o.act = st_i.cl_is_base ? fcc_pkg::ACT_RES_CL : fcc_pkg::ACT_NONE;
          fcc_pkg::OP_PREV:
            cmd_o.act = st_i.cl_below_base ? fcc_pkg::ACT_SET_NONE : fcc_pkg::ACT_NONE;
          fcc_pkg::OP_ALLOC:      cmd_o.act = fcc_pkg::ACT_NONE;
          fcc_pkg::OP_FREE_CHAIN: cmd_o.act = fcc_pkg::ACT_DIRTY_SET;
          default:                cmd_o.act = fcc_pkg::ACT_DIRTY_CLR;
        endcase
      end
      fcc_pkg::S_READ_EVAL: cmd_o.act = fcc_pkg::ACT_RES_RDATA;
      fcc_pkg::S_NEXT_EVAL: begin
        cmd_o.act = st_i.rd_end ? fcc_pkg::ACT_SET_NONE : fcc_pkg::ACT_RES_LINK;
      end
      fcc_pkg::S_LAST_CHK: begin
        if (!st_i.cur_idx_in_range) cmd_o.act = fcc_pkg::ACT_RES_CUR;
        else if (st_i.cnt_at_n) cmd_o.act = fcc_pkg::ACT_SET_LONG;
        else cmd_o.act = fcc_pkg::ACT_RD_CUR_IDX;
      end
      fcc_pkg::S_LAST_EVAL: begin
        if (st_i.rd_end || st_i.rd_next_zero) cmd_o.act = fcc_pkg::ACT_RES_CUR;
        else cmd_o.act = fcc_pkg::ACT_CUR_LINK;
      end
      fcc_pkg::S_SCAN_CHK: begin
        cmd_o.act = st_i.scan_done ? fcc_pkg::ACT_SET_NONE : fcc_pkg::ACT_RD_SCAN;
      end
      fcc_pkg::S_SCAN_EVAL: begin
        cmd_o.act = st_i.rd_match ? fcc_pkg::ACT_RES_SCAN : fcc_pkg::ACT_SCAN_NEXT;
      end
      fcc_pkg::S_ALLOC_LINK: begin
        // drop the link write when the cluster's table entry is out of range
        cmd_o.act = st_i.entry_in_range ? fcc_pkg::ACT_WR_ENTRY : fcc_pkg::ACT_NONE;
      end
      fcc_pkg::S_ALLOC_END: cmd_o.act = fcc_pkg::ACT_WR_END;
      fcc_pkg::S_FREE_CHK: begin
        if (st_i.cur_raw_end) cmd_o.act = fcc_pkg::ACT_NONE;
        else if (st_i.cnt_at_n) cmd_o.act = fcc_pkg::ACT_SET_LONG;
        else cmd_o.act = fcc_pkg::ACT_RD_CUR;
      end
      fcc_pkg::S_FREE_EVAL: cmd_o.act = fcc_pkg::ACT_FREE_STEP;
      fcc_pkg::S_DONE: begin
        cmd_o.push = !st_i.out_busy;
      end
      default: cmd_o.act = fcc_pkg::ACT_NONE;
    endcase
  end

endmodule

FILE: sv/fcc_dp.sv
`timescale 1ns / 1ps
// Datapath of the cluster chain engine: request and walk registers, config
// registers, link table RAM and output register. Depends on fcc_pkg, fcc_ram.
module fcc_dp #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fcc_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fcc_pkg::out_t                      out_data_o,
  input  logic                               cfg_we_i,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fcc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  fcc_pkg::dp_cmd_t                   cmd_i,
  output fcc_pkg::dp_status_t                st_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW    = fcc_pkg::CLUSTER_W;
  localparam int unsigned LW    = fcc_pkg::LEN_W;

  // config and control state
  logic [CW-1:0] base_q;
  logic [LW-1:0] entries_q;
  logic          dirty_q;
  logic          out_valid_q;
  fcc_pkg::out_t out_q;

  // request and walk state
  fcc_pkg::opcode_e        op_q;
  logic [CW-1:0]           cl_q, val_q, cur_q, scan_q, res_q;
  logic [LW-1:0]           cnt_q;
  logic [fcc_pkg::STATUS_W-1:0] st_q;

  logic [LW-1:0] n_len;
  logic [CW-1:0] n_w, idx_w, cur_idx_w, entry_w, link_cl_w, ram_rdata;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0]    ram_wdata;

  // effective table length
  assign n_len = (32'(entries_q) > TABLE_ENTRIES) ? LW'(TABLE_ENTRIES) : entries_q;
  assign n_w   = CW'(n_len);

  assign idx_w     = cl_q - base_q;
  assign cur_idx_w = cur_q - base_q;
  assign entry_w   = (cl_q < base_q) ? '0 : idx_w;
  assign link_cl_w = ram_rdata + base_q;

  always_comb begin
    st_o.op               = op_q;
    st_o.cl_in_range      = cl_q < n_w;
    st_o.idx_in_range     = idx_w < n_w;
    st_o.cl_is_base       = cl_q == base_q;
    st_o.cl_below_base    = cl_q < base_q;
    st_o.cl_zero          = cl_q == '0;
    st_o.entry_in_range   = entry_w < n_w;
    st_o.cur_idx_in_range = cur_idx_w < n_w;
    st_o.cur_raw_end      = (cur_q == fcc_pkg::LINK_END) || (cur_q == fcc_pkg::LINK_FREE) ||
                            (cur_q >= n_w);
    st_o.cnt_at_n         = cnt_q == n_len;
    st_o.scan_done        = scan_q >= n_w;
    st_o.rd_end           = ram_rdata == fcc_pkg::LINK_END;
    st_o.rd_next_zero     = link_cl_w == '0;
    st_o.rd_match         = (op_q == fcc_pkg::OP_ALLOC) ? (ram_rdata == fcc_pkg::LINK_FREE)
                                                        : (ram_rdata == idx_w);
    st_o.out_busy         = out_valid_q & out_stall_i;
  end

  // table port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (cmd_i.act)
      fcc_pkg::ACT_WR_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = cl_q[IDX_W-1:0];
        ram_wdata = val_q;
      end
      fcc_pkg::ACT_RD_CL: begin
        ram_re    = 1'b1;
        ram_raddr = cl_q[IDX_W-1:0];
      end
      fcc_pkg::ACT_RD_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = idx_w[IDX_W-1:0];
      end
      fcc_pkg::ACT_RD_CUR_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = cur_idx_w[IDX_W-1:0];
      end
      fcc_pkg::ACT_RD_CUR: begin
        ram_re    = 1'b1;
        ram_raddr = cur_q[IDX_W-1:0];
      end
      fcc_pkg::ACT_RD_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_q[IDX_W-1:0];
      end
      fcc_pkg::ACT_FREE_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q[IDX_W-1:0];
        ram_wdata = fcc_pkg::LINK_FREE;
      end
      fcc_pkg::ACT_WR_ENTRY: begin
        ram_we    = 1'b1;
        ram_waddr = entry_w[IDX_W-1:0];
        ram_wdata = scan_q;
      end
      fcc_pkg::ACT_WR_END: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[IDX_W-1:0];
        ram_wdata = fcc_pkg::LINK_END;
      end
      default: ;
    endcase
  end

  fcc_ram #(
    .WIDTH(CW),
    .DEPTH(TABLE_ENTRIES)
  ) u_link_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      entries_q   <= fcc_pkg::ENTRIES_RESET;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fcc_pkg::CFG_DATA_BASE:      base_q    <= cfg_data_i;
          fcc_pkg::CFG_ENTRIES_IN_USE: entries_q <= cfg_data_i[LW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.act == fcc_pkg::ACT_DIRTY_SET || cmd_i.act == fcc_pkg::ACT_WR_END) begin
        dirty_q <= 1'b1;
      end else if (cmd_i.act == fcc_pkg::ACT_DIRTY_CLR) begin
        dirty_q <= 1'b0;
      end
      // hold the result until the receiver takes it
      out_valid_q <= cmd_i.push | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.result_cluster <= res_q;
      out_q.status         <= st_q;
      out_q.table_dirty    <= dirty_q;
    end
    case (cmd_i.act)
      fcc_pkg::ACT_CAPTURE: begin
        op_q   <= fcc_pkg::opcode_e'(in_data_i.opcode);
        cl_q   <= in_data_i.cluster;
        val_q  <= in_data_i.entry_value;
        cur_q  <= in_data_i.cluster;
        res_q  <= '0;
        st_q   <= fcc_pkg::STAT_OK;
        cnt_q  <= '0;
        // allocation never hands out the two reserved entries
        scan_q <= (fcc_pkg::opcode_e'(in_data_i.opcode) == fcc_pkg::OP_ALLOC) ? 16'd2 : 16'd0;
      end
      fcc_pkg::ACT_RD_CUR_IDX: cnt_q  <= cnt_q + 1'b1;
      fcc_pkg::ACT_RES_RDATA:  res_q  <= ram_rdata;
      fcc_pkg::ACT_RES_LINK:   res_q  <= link_cl_w;
      fcc_pkg::ACT_RES_CUR:    res_q  <= cur_q;
      fcc_pkg::ACT_RES_CL:     res_q  <= cl_q;
      fcc_pkg::ACT_RES_SCAN:   res_q  <= scan_q + base_q;
      fcc_pkg::ACT_SET_NONE:   st_q   <= fcc_pkg::STAT_NONE;
      fcc_pkg::ACT_SET_LONG: begin
        res_q <= '0;
        st_q  <= fcc_pkg::STAT_LONG;
      end
      fcc_pkg::ACT_CUR_LINK:   cur_q  <= link_cl_w;
      fcc_pkg::ACT_SCAN_NEXT:  scan_q <= scan_q + 1'b1;
      fcc_pkg::ACT_FREE_STEP: begin
        cur_q <= ram_rdata;
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/fcc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the cluster chain engine, bound to the top level.
// Depends on fcc_pkg and fat_cluster_chain_engine.
module fcc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input fcc_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fcc_pkg::out_t out_data_o
);

  // one request at a time: an input transfer closes the input side
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a request is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == fcc_pkg::STAT_OK ||
                     out_data_o.status == fcc_pkg::STAT_NONE ||
                     out_data_o.status == fcc_pkg::STAT_LONG))
    else $error("unknown status code");

  a_long_walk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == fcc_pkg::STAT_LONG) |->
      out_data_o.result_cluster == '0)
    else $error("overlong walk returned a cluster");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind fat_cluster_chain_engine fcc_checker u_fcc_checker (.*);

FILE: sim/fat_cluster_chain_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fat_cluster_chain_engine: a shadow link table
// predicts each reply and a scoreboard compares replies in order.
// Depends on fcc_pkg and the engine RTL.
module fat_cluster_chain_engine_tb;
  import fcc_pkg::*;

  localparam int unsigned TABLE_ENTRIES   = 4096;
  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct {
    in_t  req;
    out_t reply;
  } reply_due_t;

  // Shadow of the link table and dirty flag; predicts one reply per request.
  class fat_table_shadow;
    bit [CLUSTER_W-1:0] link_tbl [TABLE_ENTRIES];
    bit                 loaded   [TABLE_ENTRIES];
    bit                 dirty;
    bit [CLUSTER_W-1:0] data_base;
    bit [LEN_W-1:0]     entries_in_use;
    reply_due_t         replies_due[$];
    int unsigned        mismatch_cnt;

    function new();
      dirty          = 1'b0;
      data_base      = '0;
      entries_in_use = ENTRIES_RESET;
      mismatch_cnt   = 0;
    endfunction

    function int unsigned eff_len();
      return (entries_in_use > TABLE_ENTRIES) ? TABLE_ENTRIES : entries_in_use;
    endfunction

    function bit [CLUSTER_W-1:0] to_idx(bit [CLUSTER_W-1:0] c);
      return c - data_base;
    endfunction

    function bit [CLUSTER_W-1:0] to_clu(bit [CLUSTER_W-1:0] i);
      return i + data_base;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DATA_BASE) data_base = data;
      else entries_in_use = data[LEN_W-1:0];
    endfunction

    function void apply_request(in_t req);
      reply_due_t         due;
      int unsigned        n;
      int unsigned        walk;
      bit                 done;
      bit [CLUSTER_W-1:0] res;
      bit [CLUSTER_W-1:0] idx;
      bit [CLUSTER_W-1:0] cur;
      bit [CLUSTER_W-1:0] nxt;
      bit [CLUSTER_W-1:0] tgt;
      int unsigned        entry;
      bit [STATUS_W-1:0]  st;
      n   = eff_len();
      res = '0;
      st  = STAT_OK;
      case (req.opcode)
        OP_LOAD: begin
          if (req.cluster < n) begin
            link_tbl[req.cluster] = req.entry_value;
            loaded[req.cluster]   = 1'b1;
          end else begin
            st = STAT_NONE;
          end
        end
        OP_READ_RAW: begin
          if (req.cluster < n) res = link_tbl[req.cluster];
          else st = STAT_NONE;
        end
        OP_NEXT: begin
          idx = to_idx(req.cluster);
          if (idx >= n || link_tbl[idx] == LINK_END) st = STAT_NONE;
          else res = to_clu(link_tbl[idx]);
        end
        OP_LAST: begin
          res = req.cluster;
          if (req.cluster != data_base) begin
            cur  = req.cluster;
            walk = 0;
            done = 1'b0;
            while (!done) begin
              idx = to_idx(cur);
              if (idx >= n) begin
                res  = cur;
                done = 1'b1;
              end else if (walk == n) begin
                res  = '0;
                st   = STAT_LONG;
                done = 1'b1;
              end else begin
                walk++;
                nxt = to_clu(link_tbl[idx]);
                if (link_tbl[idx] == LINK_END || nxt == 0) begin
                  res  = cur;
                  done = 1'b1;
                end else begin
                  cur = nxt;
                end
              end
            end
          end
        end
        OP_PREV: begin
          st = STAT_NONE;
          if (req.cluster >= data_base) begin
            tgt = req.cluster - data_base;
            for (int unsigned i = 0; i < n && st != STAT_OK; i++) begin
              if (link_tbl[i] == tgt) begin
                res = to_clu(CLUSTER_W'(i));
                st  = STAT_OK;
              end
            end
          end
        end
        OP_ALLOC: begin
          entry = (req.cluster < data_base) ? 0 : req.cluster - data_base;
          st    = STAT_NONE;
          for (int unsigned i = 2; i < n && st != STAT_OK; i++) begin
            if (link_tbl[i] == LINK_FREE) begin
              // a zero cluster only probes for space
              if (req.cluster != 0) begin
                if (entry < n) link_tbl[entry] = CLUSTER_W'(i);
                link_tbl[i] = LINK_END;
                dirty       = 1'b1;
              end
              res = to_clu(CLUSTER_W'(i));
              st  = STAT_OK;
            end
          end
        end
        OP_FREE_CHAIN: begin
          dirty = 1'b1;
          cur   = req.cluster;
          walk  = 0;
          done  = 1'b0;
          while (!done) begin
            if (cur == LINK_END || cur == LINK_FREE || cur >= n) begin
              done = 1'b1;
            end else if (walk == n) begin
              st   = STAT_LONG;
              done = 1'b1;
            end else begin
              nxt           = link_tbl[cur];
              link_tbl[cur] = LINK_FREE;
              cur           = nxt;
              walk++;
            end
          end
        end
        default: dirty = 1'b0;
      endcase
      due.req                  = req;
      due.reply.result_cluster = res;
      due.reply.status         = st;
      due.reply.table_dirty    = dirty;
      replies_due.push_back(due);
    endfunction

    function void flag(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_reply(out_t got);
      reply_due_t due;
      if (replies_due.size() == 0) begin
        flag($sformatf("reply %h/%0d/%0b with no request pending",
                       got.result_cluster, got.status, got.table_dirty));
        return;
      end
      due = replies_due.pop_front();
      if (got.result_cluster !== due.reply.result_cluster ||
          got.status !== due.reply.status ||
          got.table_dirty !== due.reply.table_dirty) begin
        flag($sformatf("op %0d cluster %h: got %h/%0d/%0b, expected %h/%0d/%0b",
                       due.req.opcode, due.req.cluster,
                       got.result_cluster, got.status, got.table_dirty,
                       due.reply.result_cluster, due.reply.status,
                       due.reply.table_dirty));
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  in_t                   in_data_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_t                  out_data_o;

  fat_table_shadow tracker = new();
  bit              in_gaps_on   = 1'b1;
  bit              out_gaps_on  = 1'b1;
  bit              hold_off_req = 1'b0;
  int unsigned     quiet_cycles = 0;

  fat_cluster_chain_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Check the reply first: a request taken at this edge cannot answer here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_reply(out_data_o);
      if (in_valid_i && !in_stall_o) tracker.apply_request(in_data_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fat_cluster_chain_engine_tb: FAIL");
      $finish;
    end
  end

  initial begin : reply_sink
    int unsigned hold;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = out_gaps_on ? $urandom_range(0, 5) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [CLUSTER_W-1:0] pick_cluster();
    int unsigned n;
    int unsigned r;
    n = tracker.eff_len();
    r = $urandom_range(0, 99);
    if (r < 70 && n > 0) return CLUSTER_W'($urandom_range(0, n - 1)) + tracker.data_base;
    if (r < 78) return tracker.data_base;
    if (r < 85) return '0;
    if (r < 90) return tracker.data_base - 1'b1;
    return CLUSTER_W'($urandom);
  endfunction

  function automatic logic [CLUSTER_W-1:0] pick_raw();
    int unsigned n;
    n = tracker.eff_len();
    if (n > 0 && $urandom_range(0, 99) < 85) return CLUSTER_W'($urandom_range(0, n - 1));
    return CLUSTER_W'($urandom);
  endfunction

  function automatic logic [CLUSTER_W-1:0] pick_link();
    int unsigned n;
    int unsigned r;
    n = tracker.eff_len();
    r = $urandom_range(0, 99);
    if (r < 30) return LINK_FREE;
    if (r < 45) return LINK_END;
    if (r < 90 && n > 0) return CLUSTER_W'($urandom_range(0, n - 1));
    return CLUSTER_W'($urandom);
  endfunction

  // Small fixed table: a short chain, a loop, a stray link and free holes.
  function automatic logic [CLUSTER_W-1:0] preset_link(int unsigned i);
    case (i)
      1, 4:    return LINK_END;
      2:       return 16'd3;
      3:       return 16'd4;
      5:       return 16'd6;
      6:       return 16'd5;
      8:       return 16'h1234;
      default: return LINK_FREE;
    endcase
  endfunction

  task automatic send_request(input opcode_e op, input logic [CLUSTER_W-1:0] cl,
                              input logic [CLUSTER_W-1:0] val);
    in_t req;
    int unsigned gap;
    req.opcode      = op;
    req.cluster     = cl;
    req.entry_value = val;
    gap = in_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain, then write both registers.
  task automatic write_registers(input logic [CLUSTER_W-1:0] base,
                                 input logic [LEN_W-1:0] count);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.replies_due.size() != 0);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DATA_BASE;
    cfg_data_i  <= base;
    @(posedge clk_i);
    cfg_index_i <= CFG_ENTRIES_IN_USE;
    cfg_data_i  <= CFG_DATA_W'(count);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_register(CFG_DATA_BASE, base);
    tracker.write_register(CFG_ENTRIES_IN_USE, CFG_DATA_W'(count));
  endtask

  // Drain, write both registers, then load every in-range entry not yet written.
  task automatic retune(input logic [CLUSTER_W-1:0] base, input logic [LEN_W-1:0] count,
                        input bit preset);
    int unsigned n;
    write_registers(base, count);
    n = tracker.eff_len();
    for (int unsigned i = 0; i < n; i++) begin
      if (!tracker.loaded[i])
        send_request(OP_LOAD, CLUSTER_W'(i), preset ? preset_link(i) : pick_link());
    end
  endtask

  task automatic run_mix(input int unsigned count);
    opcode_e             op;
    int unsigned         r;
    logic [CLUSTER_W-1:0] cl;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 64 == 0) begin
        in_gaps_on  = ($urandom_range(0, 3) != 0);
        out_gaps_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 20) op = OP_LOAD;
      else if (r < 28) op = OP_READ_RAW;
      else if (r < 43) op = OP_NEXT;
      else if (r < 58) op = OP_LAST;
      else if (r < 68) op = OP_PREV;
      else if (r < 85) op = OP_ALLOC;
      else if (r < 93) op = OP_FREE_CHAIN;
      else op = OP_CLEAN;
      if (op == OP_LOAD || op == OP_READ_RAW || op == OP_FREE_CHAIN) cl = pick_raw();
      else cl = pick_cluster();
      send_request(op, cl, (op == OP_LOAD) ? pick_link() : CLUSTER_W'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: every index is out of range
    retune(16'h8000, 13'd0, 1'b0);
    send_request(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_request(OP_READ_RAW, 16'h0000, 16'h0000);
    send_request(OP_NEXT, 16'h8000, 16'h0000);
    send_request(OP_LAST, 16'h8000, 16'h0000);
    send_request(OP_LAST, 16'h0000, 16'h0000);
    send_request(OP_PREV, 16'h7FFF, 16'h0000);
    send_request(OP_PREV, 16'h8000, 16'h0000);
    send_request(OP_ALLOC, 16'h9000, 16'h0000);
    send_request(OP_FREE_CHAIN, 16'h0000, 16'h0000);
    send_request(OP_CLEAN, 16'h0000, 16'h0000);

    retune(16'h0000, 13'd10, 1'b1);
    send_request(OP_READ_RAW, 16'd8, 16'h0000);
    send_request(OP_READ_RAW, 16'hFFFF, 16'h0000);
    send_request(OP_NEXT, 16'd2, 16'h0000);
    send_request(OP_NEXT, 16'd4, 16'h0000);
    send_request(OP_LAST, 16'd2, 16'h0000);
    send_request(OP_LAST, 16'd5, 16'h0000);
    send_request(OP_LAST, 16'd0, 16'h0000);
    send_request(OP_LAST, 16'd8, 16'h0000);
    send_request(OP_LAST, 16'd9, 16'h0000);
    send_request(OP_PREV, 16'd4, 16'h0000);
    send_request(OP_PREV, 16'd7, 16'h0000);
    send_request(OP_ALLOC, 16'd0, 16'h0000);
    send_request(OP_ALLOC, 16'd2, 16'h0000);
    send_request(OP_FREE_CHAIN, 16'd5, 16'h0000);
    send_request(OP_CLEAN, 16'd0, 16'h0000);

    retune(16'h0000, 13'd16, 1'b0);
    run_mix(120);
    retune(16'h0100, 13'd64, 1'b0);
    run_mix(150);
    // stall the reply side long enough to back up the request side
    retune(16'hFFF0, 13'd32, 1'b0);
    hold_off_req = 1'b1;
    run_mix(150);
    retune(CLUSTER_W'($urandom), 13'd2, 1'b0);
    run_mix(40);
    retune(CLUSTER_W'($urandom), 13'd1, 1'b0);
    run_mix(30);
    // oversized entry count: the length clips to the table size
    write_registers(16'hFFFF, 13'd8191);
    send_request(OP_LOAD, 16'd4095, LINK_END);
    send_request(OP_LOAD, 16'd4096, 16'h0001);
    send_request(OP_READ_RAW, 16'd4095, 16'h0000);
    send_request(OP_READ_RAW, 16'd4096, 16'h0000);
    send_request(OP_NEXT, 16'd4094, 16'h0000);
    send_request(OP_LAST, 16'd4094, 16'h0000);
    send_request(OP_NEXT, 16'd4095, 16'h0000);
    retune(16'h0000, 13'd100, 1'b0);
    run_mix(60);
    repeat (4) begin
      retune(CLUSTER_W'($urandom), LEN_W'($urandom_range(3, 48)), 1'b0);
      run_mix(100);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatch_cnt == 0) begin
      $display("fat_cluster_chain_engine_tb: PASS");
    end else begin
      $display("fat_cluster_chain_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fcc_pkg.sv
sv/fcc_ram.sv
sv/fcc_ctrl.sv
sv/fcc_dp.sv
sv/fat_cluster_chain_engine.sv
sv/fcc_checker.sv
sim/fat_cluster_chain_engine_tb.sv
